FILE: src/tvj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick package
// Shared widths, event codes and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tvj_pkg;

  localparam int KindW = 2;
  localparam int PosW  = 16;
  localparam int IdW   = 8;
  localparam int RadW  = 15;
  localparam int NormW = 16;

  // Magnitude of a coordinate difference and the multiplier product.
  localparam int MagW  = 16;
  localparam int ProdW = 2 * MagW;

  // Sum of squares, padded to an even width for the two-bit root steps.
  localparam int SumW      = 34;
  localparam int RootW     = SumW / 2;
  localparam int SqrtRemW  = RootW + 1;
  localparam int SqrtIters = RootW;

  // Restoring divider: 31-bit dividend, 17-bit divisor, 15 quotient bits.
  localparam int DvdW     = 31;
  localparam int DivisorW = 17;
  localparam int QuotW    = 15;
  localparam int DivIters = QuotW;

  localparam int CntW = $clog2(SqrtIters);

  localparam int NormShift = 14;
  localparam logic [NormW-1:0] NormOne = NormW'(1 << NormShift);

  localparam logic [RadW-1:0] RadiusReset = RadW'(880);

  localparam logic [KindW-1:0] KindPress   = 2'd0;
  localparam logic [KindW-1:0] KindMove    = 2'd1;
  localparam logic [KindW-1:0] KindRelease = 2'd2;
  localparam logic [KindW-1:0] KindForce   = 2'd3;

  typedef enum logic [2:0] {
    MulSqX,
    MulSqY,
    MulSqR,
    MulScX,
    MulScY
  } tvj_mul_sel_e;

  typedef struct packed {
    logic         accept;
    logic         mul_en;
    tvj_mul_sel_e mul_sel;
    logic         sum_first;
    logic         sum_add;
    logic         sqrt_init;
    logic         sqrt_step;
    logic         load_clamp_x;
    logic         load_clamp_y;
    logic         load_norm;
    logic         div_step;
    logic         off_delta;
    logic         off_div;
    logic         out_load;
  } tvj_cmd_t;

  typedef struct packed {
    logic move_hit;
    logic clamp;
    logic out_busy;
  } tvj_status_t;

endpackage

FILE: src/touch_virtual_joystick_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick
// On-screen joystick driven by touch events, with radial clamping of the
// thumb offset and a normalized Q1.14 output vector.
// ----------------------------------------------------------------------------
// Usage: touch events enter on the input channel (in_valid_i, in_stall_o)
// and one result per event leaves on the output channel (out_valid_o,
// out_stall_i); a transfer takes place at a clock edge with valid high and
// stall low. A press, a release and a move from a non-owner go straight to
// the normalizing divide. A move from the owner first compares its offset
// with the circle, and one that must be clamped onto the circle also takes
// the square root and a clamping divide. The next event can transfer in the
// cycle after the result is loaded. The processing time is set by the
// 17-step square root unit and the two 15-step divider passes, all driven
// by one controller that works on one event at a time. The output register
// frees the block to take the next event while a result still waits, so a
// stalled receiver only holds the block once a second result is ready. The
// clamp radius is written through cfg_we_i and cfg_data_i; the user must do
// so only while no event is in flight, as the block does not enforce it. A
// value of zero acts as one. Reset idles the joystick, clears its origin,
// offset and owner, sets the radius to 880 and empties the output register.
// ----------------------------------------------------------------------------
module touch_virtual_joystick_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tvj_pkg::RadW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tvj_pkg::KindW-1:0]         kind_i,
  input  logic signed [tvj_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [tvj_pkg::PosW-1:0]   pos_y_i,
  input  logic [tvj_pkg::IdW-1:0]           touch_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_active_o,
  output logic signed [tvj_pkg::NormW-1:0]  norm_x_o,
  output logic signed [tvj_pkg::NormW-1:0]  norm_y_o
);

  tvj_pkg::tvj_cmd_t    cmd;
  tvj_pkg::tvj_status_t status;

  // The controller owns the input handshake and the sequencing.
  tvj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the joystick state, the arithmetic units and the
  // output register, and drives the output handshake.
  tvj_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .touch_id_i  (touch_id_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_active_o (is_active_o),
    .norm_x_o    (norm_x_o),
    .norm_y_o    (norm_y_o)
  );

endmodule

FILE: src/tvj_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick divider lane
// Restoring divider that retires one quotient bit per step. The upper part
// of the dividend must be below the divisor, so the quotient fits in QuotW.
// ----------------------------------------------------------------------------
module tvj_div_lane (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic                              step_i,
  input  logic [tvj_pkg::DvdW-1:0]          dividend_i,
  input  logic [tvj_pkg::DivisorW-1:0]      divisor_i,
  output logic [tvj_pkg::QuotW-1:0]         quot_o
);

  logic [tvj_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [tvj_pkg::DivisorW-1:0] div_q;
  logic [tvj_pkg::QuotW-1:0]    bits_q, bits_d;
  logic [tvj_pkg::DivisorW:0]   trial;
  logic [tvj_pkg::DivisorW:0]   diff;
  logic                         ge;

  // The low register shifts dividend bits out at the top and quotient bits
  // in at the bottom, so it holds the quotient after the last step.
  always_comb begin
    trial  = {rem_q, bits_q[tvj_pkg::QuotW-1]};
    diff   = trial - {1'b0, div_q};
    ge     = (trial >= {1'b0, div_q});
    rem_d  = ge ? diff[tvj_pkg::DivisorW-1:0] : trial[tvj_pkg::DivisorW-1:0];
    bits_d = {bits_q[tvj_pkg::QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q  <= {1'b0, dividend_i[tvj_pkg::DvdW-1:tvj_pkg::QuotW]};
      bits_q <= dividend_i[tvj_pkg::QuotW-1:0];
      div_q  <= divisor_i;
    end else if (step_i) begin
      rem_q  <= rem_d;
      bits_q <= bits_d;
    end
  end

  assign quot_o = bits_q;

endmodule

FILE: src/tvj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick controller
// Sequences one event through the shared multiplier, the root unit and the
// divider lanes, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tvj_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tvj_pkg::tvj_status_t status_i,
  output tvj_pkg::tvj_cmd_t    cmd_o
);

  localparam int StW = 4;
  localparam logic [StW-1:0] StIdle   = 4'd0;
  localparam logic [StW-1:0] StDecide = 4'd1;
  localparam logic [StW-1:0] StSqX    = 4'd2;
  localparam logic [StW-1:0] StSqY    = 4'd3;
  localparam logic [StW-1:0] StSqR    = 4'd4;
  localparam logic [StW-1:0] StCmp    = 4'd5;
  localparam logic [StW-1:0] StSqrt   = 4'd6;
  localparam logic [StW-1:0] StMulX   = 4'd7;
  localparam logic [StW-1:0] StMulY   = 4'd8;
  localparam logic [StW-1:0] StLoadY  = 4'd9;
  localparam logic [StW-1:0] StDivC   = 4'd10;
  localparam logic [StW-1:0] StOffset = 4'd11;
  localparam logic [StW-1:0] StNLoad  = 4'd12;
  localparam logic [StW-1:0] StNDiv   = 4'd13;
  localparam logic [StW-1:0] StFin    = 4'd14;

  logic [StW-1:0]           state_q, state_d;
  logic [tvj_pkg::CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StDecide;
        end
      end
      StDecide: begin
        state_d = status_i.move_hit ? StSqX : StNLoad;
      end
      StSqX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tvj_pkg::MulSqX;
        state_d       = StSqY;
      end
      StSqY: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = tvj_pkg::MulSqY;
        cmd_o.sum_first = 1'b1;
        state_d         = StSqR;
      end
      StSqR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tvj_pkg::MulSqR;
        cmd_o.sum_add = 1'b1;
        state_d       = StCmp;
      end
      StCmp: begin
        if (status_i.clamp) begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d           = tvj_pkg::CntW'(tvj_pkg::SqrtIters - 1);
          state_d         = StSqrt;
        end else begin
          cmd_o.off_delta = 1'b1;
          state_d         = StNLoad;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StMulX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StMulX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tvj_pkg::MulScX;
        state_d       = StMulY;
      end
      StMulY: begin
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = tvj_pkg::MulScY;
        cmd_o.load_clamp_x = 1'b1;
        state_d            = StLoadY;
      end
      StLoadY: begin
        cmd_o.load_clamp_y = 1'b1;
        cnt_d              = tvj_pkg::CntW'(tvj_pkg::DivIters - 1);
        state_d            = StDivC;
      end
      StDivC: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StOffset;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StOffset: begin
        cmd_o.off_div = 1'b1;
        state_d       = StNLoad;
      end
      StNLoad: begin
        cmd_o.load_norm = 1'b1;
        cnt_d           = tvj_pkg::CntW'(tvj_pkg::DivIters - 1);
        state_d         = StNDiv;
      end
      StNDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StFin: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StDecide))
    else $error("accepted event did not start processing");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_clamp_x, cmd_o.load_clamp_y, cmd_o.load_norm, cmd_o.div_step}))
    else $error("divider lanes loaded and stepped at once");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("result loaded over a stalled result");
`endif

endmodule

FILE: src/tvj_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick datapath
// Joystick state, radius register, shared multiplier, square root unit,
// two divider lanes and the output register.
// ----------------------------------------------------------------------------
module tvj_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tvj_pkg::RadW-1:0]          cfg_data_i,
  input  logic [tvj_pkg::KindW-1:0]         kind_i,
  input  logic signed [tvj_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [tvj_pkg::PosW-1:0]   pos_y_i,
  input  logic [tvj_pkg::IdW-1:0]           touch_id_i,
  input  tvj_pkg::tvj_cmd_t                 cmd_i,
  output tvj_pkg::tvj_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_active_o,
  output logic signed [tvj_pkg::NormW-1:0]  norm_x_o,
  output logic signed [tvj_pkg::NormW-1:0]  norm_y_o
);

  localparam int PosW  = tvj_pkg::PosW;
  localparam int MagW  = tvj_pkg::MagW;
  localparam int RadW  = tvj_pkg::RadW;
  localparam int NormW = tvj_pkg::NormW;
  localparam int QuotW = tvj_pkg::QuotW;
  localparam int SumW  = tvj_pkg::SumW;
  localparam int RootW = tvj_pkg::RootW;
  localparam int SRemW = tvj_pkg::SqrtRemW;

  // Architectural state.
  logic [RadW-1:0]             radius_q;
  logic                        engaged_q;
  logic [tvj_pkg::IdW-1:0]     owner_q;
  logic signed [PosW-1:0]      origin_x_q, origin_y_q;
  logic signed [PosW-1:0]      off_x_q, off_y_q;
  logic                        move_hit_q;

  // Working registers.
  logic [MagW-1:0]             mag_x_q, mag_y_q;
  logic                        neg_x_q, neg_y_q;
  logic [tvj_pkg::ProdW-1:0]   prod_q;
  logic [SumW-1:0]             sum_q;
  logic [SRemW-1:0]            srem_q;
  logic [RootW-1:0]            root_q;

  // Output register.
  logic                        out_valid_q;
  logic                        is_active_q;
  logic signed [NormW-1:0]     norm_x_q, norm_y_q;

  logic [RadW-1:0]             r_eff;
  logic                        owner_hit;
  logic [PosW:0]               dx, dy, dx_neg, dy_neg;
  logic [MagW-1:0]             mag_x_d, mag_y_d;
  logic [MagW-1:0]             mul_a, mul_b;
  logic [tvj_pkg::ProdW-1:0]   prod_d;
  logic [SRemW+1:0]            sq_bring, sq_trial, sq_diff;
  logic                        sq_ge;
  logic [QuotW-1:0]            quot_x, quot_y;
  logic [QuotW-1:0]            omag_x, omag_y;
  logic [PosW-1:0]             off_x_neg, off_y_neg;
  logic                        sat_x, sat_y;
  logic [NormW-1:0]            nmag_x, nmag_y;
  logic [tvj_pkg::DvdW-1:0]    dvd_x, dvd_y, ndvd_x, ndvd_y;
  logic [tvj_pkg::DivisorW-1:0] divisor;

  // A radius of zero acts as one.
  assign r_eff     = (radius_q == '0) ? RadW'(1) : radius_q;
  assign owner_hit = engaged_q && (touch_id_i == owner_q);

  // Offset from the origin; its magnitude always fits in MagW bits.
  always_comb begin
    dx      = {pos_x_i[PosW-1], pos_x_i} - {origin_x_q[PosW-1], origin_x_q};
    dy      = {pos_y_i[PosW-1], pos_y_i} - {origin_y_q[PosW-1], origin_y_q};
    dx_neg  = '0 - dx;
    dy_neg  = '0 - dy;
    mag_x_d = dx[PosW] ? dx_neg[MagW-1:0] : dx[MagW-1:0];
    mag_y_d = dy[PosW] ? dy_neg[MagW-1:0] : dy[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= tvj_pkg::RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engaged_q  <= 1'b0;
      owner_q    <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      off_x_q    <= '0;
      off_y_q    <= '0;
      move_hit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      move_hit_q <= (kind_i == tvj_pkg::KindMove) && owner_hit;
      unique case (kind_i)
        tvj_pkg::KindPress: begin
          if (!engaged_q) begin
            origin_x_q <= pos_x_i;
            origin_y_q <= pos_y_i;
            off_x_q    <= '0;
            off_y_q    <= '0;
            owner_q    <= touch_id_i;
            engaged_q  <= 1'b1;
          end
        end
        tvj_pkg::KindMove: begin
        end
        tvj_pkg::KindRelease: begin
          if (owner_hit) begin
            engaged_q <= 1'b0;
            owner_q   <= '0;
          end
        end
        tvj_pkg::KindForce: begin
          engaged_q <= 1'b0;
          owner_q   <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.off_delta) begin
      // Inside the circle the offset is at most the radius.
      off_x_q <= neg_x_q ? PosW'('0 - mag_x_q) : mag_x_q;
      off_y_q <= neg_y_q ? PosW'('0 - mag_y_q) : mag_y_q;
    end else if (cmd_i.off_div) begin
      off_x_q <= neg_x_q ? PosW'('0 - {1'b0, quot_x}) : {1'b0, quot_x};
      off_y_q <= neg_y_q ? PosW'('0 - {1'b0, quot_y}) : {1'b0, quot_y};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      neg_x_q <= dx[PosW];
      neg_y_q <= dy[PosW];
    end
  end

  // Shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      tvj_pkg::MulSqX: begin
        mul_a = mag_x_q;
        mul_b = mag_x_q;
      end
      tvj_pkg::MulSqY: begin
        mul_a = mag_y_q;
        mul_b = mag_y_q;
      end
      tvj_pkg::MulSqR: begin
        mul_a = {1'b0, r_eff};
        mul_b = {1'b0, r_eff};
      end
      tvj_pkg::MulScX: begin
        mul_a = mag_x_q;
        mul_b = {1'b0, r_eff};
      end
      tvj_pkg::MulScY: begin
        mul_a = mag_y_q;
        mul_b = {1'b0, r_eff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = {{MagW{1'b0}}, mul_a} * {{MagW{1'b0}}, mul_b};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Digit-by-digit square root, two radicand bits per step.
  always_comb begin
    sq_bring = {srem_q, sum_q[SumW-1:SumW-2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_diff  = sq_bring - sq_trial;
    sq_ge    = (sq_bring >= sq_trial);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_first) begin
      sum_q <= {{(SumW - tvj_pkg::ProdW){1'b0}}, prod_q};
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + {{(SumW - tvj_pkg::ProdW){1'b0}}, prod_q};
    end else if (cmd_i.sqrt_step) begin
      sum_q <= {sum_q[SumW-3:0], 2'b00};
    end
    if (cmd_i.sqrt_init) begin
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sq_ge ? sq_diff[SRemW-1:0] : sq_bring[SRemW-1:0];
      root_q <= {root_q[RootW-2:0], sq_ge};
    end
  end

  // Normalization: |offset| * 2^14 / r, saturating once |offset| reaches r.
  always_comb begin
    off_x_neg = '0 - off_x_q;
    off_y_neg = '0 - off_y_q;
    omag_x    = off_x_q[PosW-1] ? off_x_neg[QuotW-1:0] : off_x_q[QuotW-1:0];
    omag_y    = off_y_q[PosW-1] ? off_y_neg[QuotW-1:0] : off_y_q[QuotW-1:0];
    sat_x     = (omag_x >= r_eff);
    sat_y     = (omag_y >= r_eff);
    ndvd_x    = {2'b00, omag_x, {tvj_pkg::NormShift{1'b0}}};
    ndvd_y    = {2'b00, omag_y, {tvj_pkg::NormShift{1'b0}}};
    dvd_x     = cmd_i.load_norm ? ndvd_x : prod_q[tvj_pkg::DvdW-1:0];
    dvd_y     = cmd_i.load_norm ? ndvd_y : prod_q[tvj_pkg::DvdW-1:0];
    divisor   = cmd_i.load_norm ? {2'b00, r_eff} : root_q;
    nmag_x    = sat_x ? tvj_pkg::NormOne : {1'b0, quot_x};
    nmag_y    = sat_y ? tvj_pkg::NormOne : {1'b0, quot_y};
  end

  tvj_div_lane u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_clamp_x | cmd_i.load_norm),
    .step_i     (cmd_i.div_step),
    .dividend_i (dvd_x),
    .divisor_i  (divisor),
    .quot_o     (quot_x)
  );

  tvj_div_lane u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_clamp_y | cmd_i.load_norm),
    .step_i     (cmd_i.div_step),
    .dividend_i (dvd_y),
    .divisor_i  (divisor),
    .quot_o     (quot_y)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      is_active_q <= engaged_q;
      if (engaged_q) begin
        norm_x_q <= off_x_q[PosW-1] ? NormW'('0 - nmag_x) : nmag_x;
        norm_y_q <= off_y_q[PosW-1] ? NormW'('0 - nmag_y) : nmag_y;
      end else begin
        norm_x_q <= '0;
        norm_y_q <= '0;
      end
    end
  end

  assign status_o.move_hit = move_hit_q;
  assign status_o.clamp    = (sum_q > {{(SumW - tvj_pkg::ProdW){1'b0}}, prod_q});
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign is_active_o = is_active_q;
  assign norm_x_o    = norm_x_q;
  assign norm_y_o    = norm_y_q;

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (norm_x_q <= $signed(tvj_pkg::NormOne))
                 && (norm_x_q >= -$signed(tvj_pkg::NormOne))
                 && (norm_y_q <= $signed(tvj_pkg::NormOne))
                 && (norm_y_q >= -$signed(tvj_pkg::NormOne)))
    else $error("normalized thumb vector out of range");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_active_q) |-> (norm_x_q == '0) && (norm_y_q == '0))
    else $error("idle result carries a nonzero vector");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(is_active_q)
                                  && $stable(norm_x_q) && $stable(norm_y_q))
    else $error("stalled result changed before its transfer");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch virtual joystick testbench
// Feeds touch events (press, move, release, forced release) into the joystick
// and checks every result against a cycle-free model of the stick: ownership,
// origin capture, radial clamping of the thumb offset and the Q1.14
// normalization. The clamp radius is swept through its extremes between
// phases, both channels idle at random, and one phase holds the receiver off
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int KindW = tvj_pkg::KindW;
  localparam int PosW  = tvj_pkg::PosW;
  localparam int IdW   = tvj_pkg::IdW;
  localparam int RadW  = tvj_pkg::RadW;
  localparam int NormW = tvj_pkg::NormW;

  // This limit leaves a wide margin over the slowest event, even with both
  // sides idling half of the time.
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles  = 400;

  // One joystick reading as the block reports it after each event.
  typedef struct {
    logic                    active;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
  } stick_reading_t;

  // Every block input holds a known value from time zero.
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [RadW-1:0]         cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic [KindW-1:0]        kind      = tvj_pkg::KindPress;
  logic signed [PosW-1:0]  pos_x     = '0;
  logic signed [PosW-1:0]  pos_y     = '0;
  logic [IdW-1:0]          touch_id  = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic                    is_active;
  logic signed [NormW-1:0] norm_x;
  logic signed [NormW-1:0] norm_y;

  // Shadow copy of the joystick state and its radius register.
  logic [RadW-1:0] radius_q   = tvj_pkg::RadiusReset;
  logic            engaged_q  = 1'b0;
  logic [IdW-1:0]  owner_q    = '0;
  int              origin_x_q = 0;
  int              origin_y_q = 0;
  longint          offset_x_q = 0;
  longint          offset_y_q = 0;

  // Readings predicted for accepted events, oldest first.
  stick_reading_t readings_due[$];

  int unsigned events_sent    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Idle rates in percent; the first phase has the sender idle 38 percent of
  // the time and the receiver 50 percent.
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 50;

  // A one-cycle pulse starts a long receiver hold-off.
  logic hold_start = 1'b0;
  int   hold_left  = 0;

  touch_virtual_joystick_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .touch_id_i  (touch_id),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .is_active_o (is_active),
    .norm_x_o    (norm_x),
    .norm_y_o    (norm_y)
  );

  always #2 clk = ~clk;

  // Run limit. Hitting it means a transfer never happened.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver side. During a hold-off the stall stays high for the whole
  // count; otherwise it is drawn at the current idle rate.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= hold_start || (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Bit-by-bit floor square root; the sum of squares stays below 2**34,
  // so the root needs 17 bits at most.
  function automatic longint floor_sqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // v * num / den with truncation toward zero, capped at limit in magnitude.
  function automatic longint scale_toward_zero(input longint v, input longint num,
                                               input longint den, input longint limit);
    longint quot;
    quot = ((v < 0) ? -v : v) * num / den;
    if (quot > limit) quot = limit;
    return (v < 0) ? -quot : quot;
  endfunction

  // Applies one event to the shadow state and returns the reading the block
  // must report for it.
  function automatic stick_reading_t predict_stick_reading(
      input logic [KindW-1:0] kind_v, input logic signed [PosW-1:0] px,
      input logic signed [PosW-1:0] py, input logic [IdW-1:0] id);
    stick_reading_t reading;
    longint r;
    longint dx;
    longint dy;
    longint sum_sq;
    longint root;
    // A radius of zero acts as one.
    r = (radius_q == '0) ? 1 : longint'(radius_q);
    case (kind_v)
      tvj_pkg::KindPress: begin
        // A press only engages an idle stick and starts from a zero offset.
        if (!engaged_q) begin
          origin_x_q = px;
          origin_y_q = py;
          offset_x_q = 0;
          offset_y_q = 0;
          owner_q    = id;
          engaged_q  = 1'b1;
        end
      end
      tvj_pkg::KindMove: begin
        if (engaged_q && id == owner_q) begin
          dx     = longint'(px) - origin_x_q;
          dy     = longint'(py) - origin_y_q;
          sum_sq = dx * dx + dy * dy;
          // Outside the circle the offset is pulled back onto it.
          if (sum_sq > r * r) begin
            root       = floor_sqrt(sum_sq);
            offset_x_q = scale_toward_zero(dx, r, root, r);
            offset_y_q = scale_toward_zero(dy, r, root, r);
          end else begin
            offset_x_q = dx;
            offset_y_q = dy;
          end
        end
      end
      tvj_pkg::KindRelease: begin
        if (engaged_q && id == owner_q) begin
          engaged_q = 1'b0;
          owner_q   = '0;
        end
      end
      default: begin
        engaged_q = 1'b0;
        owner_q   = '0;
      end
    endcase
    reading.active = engaged_q;
    reading.nx = '0;
    reading.ny = '0;
    if (engaged_q) begin
      reading.nx = NormW'(scale_toward_zero(offset_x_q, longint'(tvj_pkg::NormOne), r,
                                            longint'(tvj_pkg::NormOne)));
      reading.ny = NormW'(scale_toward_zero(offset_y_q, longint'(tvj_pkg::NormOne), r,
                                            longint'(tvj_pkg::NormOne)));
    end
    return reading;
  endfunction

  // Result checker: each output transfer is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    stick_reading_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("result transfer with no event outstanding");
      end else begin
        due = readings_due.pop_front();
        if (is_active !== due.active)
          flag_mismatch($sformatf("is_active got %b want %b", is_active, due.active));
        if (norm_x !== due.nx)
          flag_mismatch($sformatf("norm_x got %0d want %0d", norm_x, due.nx));
        if (norm_y !== due.ny)
          flag_mismatch($sformatf("norm_y got %0d want %0d", norm_y, due.ny));
      end
    end
  end

  // Offers one touch event, holds it steady while the block stalls, and
  // records the predicted reading once the transfer happens. Valid from the
  // previous event may still be high on entry; it is only lowered when an
  // idle cycle is drawn.
  task automatic post_touch(input logic [KindW-1:0] kind_v, input logic signed [PosW-1:0] px,
                            input logic signed [PosW-1:0] py, input logic [IdW-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= kind_v;
    pos_x    <= px;
    pos_y    <= py;
    touch_id <= id;
    do @(posedge clk); while (in_stall);
    readings_due.push_back(predict_stick_reading(kind_v, px, py, id));
    events_sent++;
  endtask

  // Drops valid and waits until every predicted reading has been checked.
  // Each event yields exactly one result, so the block is then idle.
  task automatic wait_readings_drained();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RadW-1:0] value);
    wait_readings_drained();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    radius_q = value;
  endtask

  // One well-formed gesture: press, a handful of moves, then a release.
  // Stray events from other pointers are mixed in to test ownership.
  task automatic play_gesture();
    logic [IdW-1:0] owner;
    logic [IdW-1:0] other;
    int r;
    int span;
    int ox;
    int oy;
    int dx;
    int dy;
    if ($urandom_range(1) == 1) owner = IdW'($urandom_range(3));
    else owner = IdW'($urandom);
    other = owner ^ IdW'($urandom_range(1, 255));
    if ($urandom_range(3) == 0) begin
      ox = int'($signed(PosW'($urandom)));
      oy = int'($signed(PosW'($urandom)));
    end else begin
      ox = int'($urandom_range(8000)) - 4000;
      oy = int'($urandom_range(8000)) - 4000;
    end
    r    = (radius_q == '0) ? 1 : int'(radius_q);
    span = (2 * r + 16 > 65535) ? 65535 : 2 * r + 16;
    post_touch(tvj_pkg::KindPress, PosW'(ox), PosW'(oy), owner);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(9))
        0: post_touch(tvj_pkg::KindMove, PosW'($urandom), PosW'($urandom), other);
        1: post_touch(tvj_pkg::KindPress, PosW'($urandom), PosW'($urandom), other);
        2: post_touch(tvj_pkg::KindMove, PosW'($urandom), PosW'($urandom), owner);
        default: begin
          // Mostly near the origin, so offsets land on both sides of the circle.
          dx = int'($urandom_range(2 * span)) - span;
          dy = int'($urandom_range(2 * span)) - span;
          post_touch(tvj_pkg::KindMove, PosW'(ox + dx), PosW'(oy + dy), owner);
        end
      endcase
    end
    case ($urandom_range(4))
      0: begin
        post_touch(tvj_pkg::KindRelease, PosW'($urandom), PosW'($urandom), other);
        post_touch(tvj_pkg::KindRelease, PosW'($urandom), PosW'($urandom), owner);
      end
      1: post_touch(tvj_pkg::KindForce, PosW'($urandom), PosW'($urandom), IdW'($urandom));
      default: post_touch(tvj_pkg::KindRelease, PosW'($urandom), PosW'($urandom), owner);
    endcase
  endtask

  // Directed events at the reset radius of 880: idle-state events, the
  // coordinate extremes, the exact circle edge, clamping, and ownership.
  task automatic test_directed_events();
    post_touch(tvj_pkg::KindMove, 16'sd100, -16'sd100, 8'd0);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd0);
    post_touch(tvj_pkg::KindForce, '0, '0, 8'd0);
    post_touch(tvj_pkg::KindPress, -16'sd32768, 16'sd32767, 8'd255);
    // A second press while engaged is ignored, as is a move by another id.
    post_touch(tvj_pkg::KindPress, '0, '0, 8'd0);
    post_touch(tvj_pkg::KindMove, '0, '0, 8'd0);
    post_touch(tvj_pkg::KindMove, -16'sd32668, 16'sd32717, 8'd255);
    post_touch(tvj_pkg::KindMove, 16'sd32767, -16'sd32768, 8'd255);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd254);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd255);
    post_touch(tvj_pkg::KindPress, 16'sd32767, -16'sd32768, 8'd0);
    post_touch(tvj_pkg::KindMove, -16'sd32768, 16'sd32767, 8'd0);
    post_touch(tvj_pkg::KindMove, 16'sd32764, -16'sd32764, 8'd0);
    post_touch(tvj_pkg::KindForce, '0, '0, 8'd7);
    // The press must clear the offset left over from the last gesture.
    post_touch(tvj_pkg::KindPress, 16'sd100, 16'sd100, 8'd128);
    post_touch(tvj_pkg::KindMove, 16'sd980, 16'sd100, 8'd128);
    post_touch(tvj_pkg::KindMove, 16'sd981, 16'sd100, 8'd128);
    post_touch(tvj_pkg::KindMove, 16'sd100, -16'sd780, 8'd128);
    post_touch(tvj_pkg::KindMove, -16'sd523, -16'sd623, 8'd128);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd128);
    post_touch(tvj_pkg::KindPress, 16'sd5, 16'sd5, 8'd128);
    post_touch(tvj_pkg::KindForce, '0, '0, 8'd128);
  endtask

  // Smallest, zero and largest radius, and a radius lowered under an
  // engaged stick so that the normalized outputs saturate.
  task automatic test_radius_extremes();
    write_radius(RadW'(1));
    post_touch(tvj_pkg::KindPress, '0, '0, 8'd5);
    post_touch(tvj_pkg::KindMove, 16'sd1, '0, 8'd5);
    post_touch(tvj_pkg::KindMove, 16'sd1, 16'sd1, 8'd5);
    post_touch(tvj_pkg::KindMove, -16'sd32768, -16'sd32768, 8'd5);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd5);
    write_radius('0);
    post_touch(tvj_pkg::KindPress, 16'sd10, -16'sd10, 8'd6);
    post_touch(tvj_pkg::KindMove, 16'sd9, -16'sd10, 8'd6);
    post_touch(tvj_pkg::KindMove, 16'sd12, -16'sd7, 8'd6);
    post_touch(tvj_pkg::KindRelease, '0, '0, 8'd6);
    write_radius(RadW'(32767));
    post_touch(tvj_pkg::KindPress, -16'sd32768, -16'sd32768, 8'd8);
    post_touch(tvj_pkg::KindMove, 16'sd32767, 16'sd32767, 8'd8);
    post_touch(tvj_pkg::KindMove, -16'sd1, -16'sd32768, 8'd8);
    post_touch(tvj_pkg::KindForce, '0, '0, 8'd0);
    post_touch(tvj_pkg::KindPress, '0, '0, 8'd9);
    post_touch(tvj_pkg::KindMove, 16'sd20000, -16'sd20000, 8'd9);
    write_radius(RadW'(100));
    post_touch(tvj_pkg::KindMove, '0, '0, 8'd10);
    post_touch(tvj_pkg::KindMove, 16'sd150, '0, 8'd9);
    write_radius(RadW'(16));
    post_touch(tvj_pkg::KindPress, '0, '0, 8'd11);
    post_touch(tvj_pkg::KindForce, '0, '0, 8'd9);
    write_radius(tvj_pkg::RadiusReset);
  endtask

  // Random traffic in four blocks, each at its own radius. Most events come
  // in well-formed gestures; the rest are random noise.
  task automatic test_random_gestures(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned n_events);
    int unsigned goal;
    logic [RadW-1:0] radius;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (4) begin
      case ($urandom_range(3))
        0: radius = tvj_pkg::RadiusReset;
        1: radius = RadW'($urandom_range(1, 64));
        2: radius = RadW'($urandom_range(1, 32767));
        default: radius = RadW'(32767);
      endcase
      write_radius(radius);
      goal = events_sent + n_events / 4;
      while (events_sent < goal) begin
        if ($urandom_range(99) < 80) begin
          play_gesture();
        end else begin
          post_touch(KindW'($urandom), PosW'($urandom), PosW'($urandom), IdW'($urandom));
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering events, so the output register and the datapath fill and the
  // block has to stall its input.
  task automatic test_output_backpressure();
    int unsigned goal;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_readings_drained();
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    goal = events_sent + 30;
    while (events_sent < goal) play_gesture();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_radius_extremes();
    test_random_gestures(38, 50, 200);
    test_random_gestures(50, 38, 200);
    test_random_gestures(0, 0, 200);
    test_output_backpressure();

    // Let any stray result show up before the verdict.
    wait_readings_drained();
    repeat (DrainCycles) @(posedge clk);
    if (readings_due.size() != 0)
      flag_mismatch($sformatf("%0d readings never arrived", readings_due.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
